>>> rtl/core/lidar_scan_to_point_cloud_unit_defines.svh
// Assertion macros for the lidar scan to point cloud unit.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef LIDAR_SCAN_TO_POINT_CLOUD_UNIT_DEFINES_SVH
`define LIDAR_SCAN_TO_POINT_CLOUD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LSC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/lsc_pkg.sv
// Shared constants and rounding helper for the lidar scan to point cloud unit.
// No dependencies.
`default_nettype none

package lsc_pkg;

   // request opcodes
   localparam logic [1:0] OP_SAMPLE    = 2'd0;
   localparam logic [1:0] OP_COL_WRITE = 2'd1;
   localparam logic [1:0] OP_RING_WRITE = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_MIN_RANGE     = 3'd0;
   localparam logic [2:0] CSR_MAX_RANGE     = 3'd1;
   localparam logic [2:0] CSR_MIN_INTENSITY = 3'd2;
   localparam logic [2:0] CSR_ORDERED_MODE  = 3'd3;
   localparam logic [2:0] CSR_COLUMNS       = 3'd4;
   localparam logic [2:0] CSR_RINGS         = 3'd5;

   localparam logic [31:0] MIN_RANGE_RST = 32'd0;
   localparam logic [31:0] MAX_RANGE_RST = 32'hFFFF_FFFF;
   localparam logic [15:0] MIN_INT_RST   = 16'd0;
   localparam logic [11:0] COLUMNS_RST   = 12'd2048;
   localparam logic [7:0]  RINGS_RST     = 8'd16;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // multiplier steps
   localparam logic [2:0] STEP_CP_CY  = 3'd0;
   localparam logic [2:0] STEP_CP_SY  = 3'd1;
   localparam logic [2:0] STEP_R_SP   = 3'd2;
   localparam logic [2:0] STEP_R_MM   = 3'd3;
   localparam logic [2:0] STEP_R_PCC  = 3'd4;
   localparam logic [2:0] STEP_R_PCS  = 3'd5;
   localparam logic [2:0] STEP_LAST   = 3'd6;

   localparam logic signed [31:0] MM_SCALE = 32'sd1000;

   // round half up from Q16.44 (wide) or Q16.30, saturate to 33-bit signed
   function automatic logic [32:0] round_sat(input logic signed [64:0] prod,
                                             input logic wide);
      logic signed [65:0] sum;
      logic signed [65:0] q;
      sum = 66'(prod) + (wide ? 66'sh800_0000 : 66'sh2000);
      q = wide ? (sum >>> 28) : (sum >>> 14);
      if (q[65:32] == '0 || q[65:32] == '1) begin
         round_sat = q[32:0];
      end else if (q[65]) begin
         round_sat = {1'b1, 32'd0};
      end else begin
         round_sat = {1'b0, {32{1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lidar_scan_to_point_cloud_unit.sv
// A sample request is accepted only while idle; the next one waits until this one
// has made six passes through the shared 33x32 multiplier and loaded the output.
// Table write requests write the table when accepted and give no response.
// Synchronous active-high reset restores registers and scan counters; trig
// tables are not cleared and must be written before use.
// Depends on lsc_pkg and lidar_scan_to_point_cloud_unit_defines.svh.
`default_nettype none
`include "lidar_scan_to_point_cloud_unit_defines.svh"

module lidar_scan_to_point_cloud_unit
   import lsc_pkg::*;
#(
   parameter int MAX_COLUMNS = 2048,
   parameter int MAX_RINGS   = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [10:0]        req_table_index,
   input  wire logic signed [15:0] req_cos_value,
   input  wire logic signed [15:0] req_sin_value,
   input  wire logic [31:0]        req_range_value,
   input  wire logic [15:0]        req_intensity_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [32:0]      rsp_point_x,
   output logic signed [32:0]      rsp_point_y,
   output logic signed [32:0]      rsp_point_z,
   output logic [15:0]             rsp_point_intensity,
   output logic [6:0]              rsp_ring_number,
   output logic [25:0]             rsp_range_millimetres,
   output logic                    rsp_keep_point,
   output logic                    rsp_end_of_scan
);

   localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW  = $clog2(MAX_COLUMNS + 1);
   localparam int CW1 = CW + 1;
   localparam int RIW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
   localparam int RW  = $clog2(MAX_RINGS + 1);

   // configuration
   logic [31:0] cfg_min_range_ff;
   logic [31:0] cfg_max_range_ff;
   logic [15:0] cfg_min_int_ff;
   logic        cfg_ordered_ff;
   logic [11:0] cfg_columns_ff;
   logic [7:0]  cfg_rings_ff;

   // scan counters and sequencer
   logic [CIW-1:0] column_step_ff, column_step_in;
   logic [RIW-1:0] ring_counter_ff, ring_counter_in;
   logic [1:0]     state_ff, state_in;
   logic [2:0]     step_ff, step_in;

   // sample payload
   logic [31:0] r_ff;
   logic [15:0] inten_ff;
   logic [6:0]  ring_ff;
   logic        keep_ff;
   logic        eos_ff;
   logic [31:0] col_rd_ff;
   logic [31:0] ring_rd_ff;
   logic signed [64:0] prod_ff;
   logic signed [31:0] pcc_ff;
   logic signed [31:0] pcs_ff;
   logic [32:0] x_ff;
   logic [32:0] y_ff;
   logic [32:0] z_ff;
   logic [25:0] mm_ff;

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [32:0] rsp_x_ff;
   logic [32:0] rsp_y_ff;
   logic [32:0] rsp_z_ff;
   logic [15:0] rsp_inten_ff;
   logic [6:0]  rsp_ring_ff;
   logic [25:0] rsp_mm_ff;
   logic        rsp_keep_ff;
   logic        rsp_eos_ff;

   logic [31:0] col_mem [MAX_COLUMNS];
   logic [31:0] ring_mem [MAX_RINGS];

   logic           accept;
   logic           sample_acc;
   logic           col_we;
   logic           ring_we;
   logic           rsp_load;
   logic           reject;
   logic           eos;
   logic [CW-1:0]  ncol;
   logic [CW-1:0]  half;
   logic [CW-1:0]  step_inc;
   logic [RW-1:0]  nring;
   logic [CIW-1:0] step_n;
   logic [RIW-1:0] ring_n;
   logic [CW1-1:0] col_wide;
   logic [CIW-1:0] col_idx;
   logic signed [15:0] cy, sy, cp, sp;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] prod_in;
   logic signed [32:0] r_signed;

   assign accept     = req_valid && req_ready;
   assign sample_acc = accept && (req_opcode == OP_SAMPLE);
   assign col_we     = accept && (req_opcode == OP_COL_WRITE)
                       && ({21'd0, req_table_index} < 32'(MAX_COLUMNS));
   assign ring_we    = accept && (req_opcode == OP_RING_WRITE)
                       && ({21'd0, req_table_index} < 32'(MAX_RINGS));
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // effective geometry
   always_comb begin
      if (cfg_columns_ff == '0) begin
         ncol = CW'(1);
      end else if ({20'd0, cfg_columns_ff} > 32'(MAX_COLUMNS)) begin
         ncol = CW'(MAX_COLUMNS);
      end else begin
         ncol = CW'(cfg_columns_ff);
      end
      if (cfg_rings_ff == '0) begin
         nring = RW'(1);
      end else if ({24'd0, cfg_rings_ff} > 32'(MAX_RINGS)) begin
         nring = RW'(MAX_RINGS);
      end else begin
         nring = RW'(cfg_rings_ff);
      end
   end

   // rotated column and ring, counter advance
   always_comb begin
      step_n = (CW'(column_step_ff) >= ncol) ? '0 : column_step_ff;
      ring_n = (RW'(ring_counter_ff) >= nring) ? RIW'(nring - RW'(1)) : ring_counter_ff;
      half   = ncol >> 1;
      if (half >= CW'(step_n)) begin
         col_wide = CW1'(half) - CW1'(step_n);
      end else begin
         col_wide = CW1'(half) + CW1'(ncol) - CW1'(step_n);
      end
      col_idx  = col_wide[CIW-1:0];
      step_inc = CW'(step_n) + CW'(1);
      eos      = 1'b0;
      column_step_in  = step_n;
      ring_counter_in = ring_n;
      if (ring_n == '0) begin
         ring_counter_in = RIW'(nring - RW'(1));
         if (step_inc >= ncol) begin
            column_step_in = '0;
            eos            = 1'b1;
         end else begin
            column_step_in = CIW'(step_inc);
         end
      end else begin
         ring_counter_in = ring_n - RIW'(1);
      end
   end

   assign reject = (cfg_min_range_ff >= req_range_value)
                   || (req_range_value >= cfg_max_range_ff)
                   || (req_intensity_value < cfg_min_int_ff);

   // trig tables: {sin, cos}
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[CIW'(req_table_index)] <= {req_sin_value, req_cos_value};
      end
      if (ring_we) begin
         ring_mem[RIW'(req_table_index)] <= {req_sin_value, req_cos_value};
      end
      if (sample_acc) begin
         col_rd_ff  <= col_mem[col_idx];
         ring_rd_ff <= ring_mem[ring_n];
      end
   end

   assign cy       = col_rd_ff[15:0];
   assign sy       = col_rd_ff[31:16];
   assign cp       = ring_rd_ff[15:0];
   assign sp       = ring_rd_ff[31:16];
   assign r_signed = $signed({1'b0, r_ff});

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         STEP_CP_CY: begin
            mul_a = 33'(cp);
            mul_b = 32'(cy);
         end
         STEP_CP_SY: begin
            mul_a = 33'(cp);
            mul_b = 32'(sy);
         end
         STEP_R_SP: begin
            mul_a = r_signed;
            mul_b = 32'(sp);
         end
         STEP_R_MM: begin
            mul_a = r_signed;
            mul_b = MM_SCALE;
         end
         STEP_R_PCC: begin
            mul_a = r_signed;
            mul_b = pcc_ff;
         end
         STEP_R_PCS: begin
            mul_a = r_signed;
            mul_b = pcs_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_acc) begin
               state_in = ST_CALC;
               step_in  = STEP_CP_CY;
            end
         end
         ST_CALC: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_range_ff <= MIN_RANGE_RST;
         cfg_max_range_ff <= MAX_RANGE_RST;
         cfg_min_int_ff   <= MIN_INT_RST;
         cfg_ordered_ff   <= 1'b0;
         cfg_columns_ff   <= COLUMNS_RST;
         cfg_rings_ff     <= RINGS_RST;
         column_step_ff   <= '0;
         ring_counter_ff  <= RIW'(MAX_RINGS - 1);
         state_ff         <= ST_IDLE;
         step_ff          <= STEP_CP_CY;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sample_acc) begin
            column_step_ff  <= column_step_in;
            ring_counter_ff <= ring_counter_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_RANGE:     cfg_min_range_ff <= csr_wdata;
               CSR_MAX_RANGE:     cfg_max_range_ff <= csr_wdata;
               CSR_MIN_INTENSITY: cfg_min_int_ff   <= csr_wdata[15:0];
               CSR_ORDERED_MODE:  cfg_ordered_ff   <= csr_wdata[0];
               CSR_COLUMNS: begin
                  cfg_columns_ff  <= csr_wdata[11:0];
                  column_step_ff  <= '0;
                  ring_counter_ff <= RIW'(MAX_RINGS - 1); // settles to rings - 1
               end
               CSR_RINGS: begin
                  cfg_rings_ff    <= csr_wdata[7:0];
                  column_step_ff  <= '0;
                  ring_counter_ff <= RIW'(MAX_RINGS - 1);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (sample_acc) begin
         r_ff     <= reject ? 32'd0 : req_range_value;
         inten_ff <= req_intensity_value;
         ring_ff  <= 7'(ring_n);
         keep_ff  <= !reject || cfg_ordered_ff;
         eos_ff   <= eos;
      end
      if (state_ff == ST_CALC) begin
         case (step_ff)
            STEP_CP_SY: pcc_ff <= prod_ff[31:0];
            STEP_R_SP:  pcs_ff <= prod_ff[31:0];
            STEP_R_MM:  z_ff   <= round_sat(prod_ff, 1'b0);
            STEP_R_PCC: mm_ff  <= prod_ff[41:16];
            STEP_R_PCS: x_ff   <= round_sat(prod_ff, 1'b1);
            STEP_LAST:  y_ff   <= round_sat(prod_ff, 1'b1);
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_z_ff     <= z_ff;
         rsp_inten_ff <= inten_ff;
         rsp_ring_ff  <= ring_ff;
         rsp_mm_ff    <= mm_ff;
         rsp_keep_ff  <= keep_ff;
         rsp_eos_ff   <= eos_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_point_x           = rsp_x_ff;
   assign rsp_point_y           = rsp_y_ff;
   assign rsp_point_z           = rsp_z_ff;
   assign rsp_point_intensity   = rsp_inten_ff;
   assign rsp_ring_number       = rsp_ring_ff;
   assign rsp_range_millimetres = rsp_mm_ff;
   assign rsp_keep_point        = rsp_keep_ff;
   assign rsp_end_of_scan       = rsp_eos_ff;

   `LSC_ASSERT_NEXT(a_sample_starts_calc, clock, reset, sample_acc, (state_ff == ST_CALC) && (step_ff == STEP_CP_CY))
   `LSC_ASSERT_NEXT(a_table_write_stays_idle, clock, reset, accept && (req_opcode != OP_SAMPLE), state_ff == ST_IDLE)
   `LSC_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `LSC_ASSERT_SAME(a_eos_on_ring_zero, clock, reset, rsp_valid_ff && rsp_eos_ff, rsp_ring_ff == 7'd0)
   `LSC_ASSERT_SAME(a_discard_is_zero, clock, reset, rsp_valid_ff && !rsp_keep_ff, (rsp_mm_ff == 26'd0) && (rsp_z_ff == 33'd0))

endmodule

`default_nettype wire

>>> verif/lidar_scan_to_point_cloud_unit_tb.sv
// Self-checking testbench for lidar_scan_to_point_cloud_unit: directed and random
// requests, an in-bench point predictor and an in-order scoreboard of expected points.
// Depends on lsc_pkg and the unit RTL.
`timescale 1ns / 1ps

module lidar_scan_to_point_cloud_unit_tb
   import lsc_pkg::*;
;

   localparam int MAX_COLUMNS = 2048;
   localparam int MAX_RINGS   = 128;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [10:0]        table_index;
      logic signed [15:0] cos_value;
      logic signed [15:0] sin_value;
      logic [31:0]        range_value;
      logic [15:0]        intensity_value;
   } req_type;

   typedef struct packed {
      logic signed [32:0] point_x;
      logic signed [32:0] point_y;
      logic signed [32:0] point_z;
      logic [15:0]        point_intensity;
      logic [6:0]         ring_number;
      logic [25:0]        range_millimetres;
      logic               keep_point;
      logic               end_of_scan;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = '0;
   logic [10:0]        req_table_index = '0;
   logic signed [15:0] req_cos_value = '0;
   logic signed [15:0] req_sin_value = '0;
   logic [31:0]        req_range_value = '0;
   logic [15:0]        req_intensity_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [32:0] rsp_point_x;
   logic signed [32:0] rsp_point_y;
   logic signed [32:0] rsp_point_z;
   logic [15:0]        rsp_point_intensity;
   logic [6:0]         rsp_ring_number;
   logic [25:0]        rsp_range_millimetres;
   logic               rsp_keep_point;
   logic               rsp_end_of_scan;

   // predictor copy of the registers and scan state
   logic [31:0] min_range_q = MIN_RANGE_RST;
   logic [31:0] max_range_q = MAX_RANGE_RST;
   logic [15:0] min_int_q   = MIN_INT_RST;
   logic        ordered_q   = 1'b0;
   logic [11:0] columns_q   = COLUMNS_RST;
   logic [7:0]  rings_q     = RINGS_RST;
   int          pred_col_step = 0;
   int          pred_ring     = 15;

   logic signed [15:0] col_cos  [MAX_COLUMNS];
   logic signed [15:0] col_sin  [MAX_COLUMNS];
   logic signed [15:0] ring_cos [MAX_RINGS];
   logic signed [15:0] ring_sin [MAX_RINGS];

   // generator view: scan position and which table entries hold data
   int gen_col_step;
   int gen_ring;
   bit col_loaded  [MAX_COLUMNS];
   bit ring_loaded [MAX_RINGS];

   req_type   pending_requests[$];
   point_type expected_points[$];
   req_type   in_flight;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        failures = 0;

   function automatic int active_columns();
      if (columns_q < 1) return 1;
      if (columns_q > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(columns_q);
   endfunction

   function automatic int active_rings();
      if (rings_q < 1) return 1;
      if (rings_q > MAX_RINGS) return MAX_RINGS;
      return int'(rings_q);
   endfunction

   // clamps the counters and gives the rotated column
   function automatic void scan_locate(inout int col_step, inout int ring, output int col);
      int ncol;
      int half;
      ncol = active_columns();
      if (col_step >= ncol) col_step = 0;
      if (ring >= active_rings()) ring = active_rings() - 1;
      half = ncol / 2;
      col = (half >= col_step) ? half - col_step : half + ncol - col_step;
   endfunction

   // returns 1 when the scan wraps
   function automatic bit scan_advance(inout int col_step, inout int ring);
      if (ring != 0) begin
         ring--;
         return 1'b0;
      end
      ring = active_rings() - 1;
      col_step++;
      if (col_step >= active_columns()) begin
         col_step = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // round half up by shift bits, saturate to 33-bit signed
   function automatic logic [32:0] round_to_q16(longint prod, int shift);
      longint q;
      q = (prod + (64'sd1 <<< (shift - 1))) >>> shift;
      if (q > 64'sd4294967295) q = 64'sd4294967295;
      else if (q < -64'sd4294967296) q = -64'sd4294967296;
      return q[32:0];
   endfunction

   function automatic point_type convert_sample(req_type rq);
      point_type pt;
      int     col;
      bit     reject;
      logic [31:0] rng;
      longint r;
      longint rc;
      longint mm;
      scan_locate(pred_col_step, pred_ring, col);
      rng = rq.range_value;
      reject = (min_range_q >= rng) || (rng >= max_range_q)
               || (rq.intensity_value < min_int_q);
      if (reject) rng = '0;
      r = longint'(rng);
      rc = r * longint'(ring_cos[pred_ring]);
      mm = r * 64'sd1000;
      pt.point_x = round_to_q16(rc * longint'(col_cos[col]), 28);
      pt.point_y = round_to_q16(rc * longint'(col_sin[col]), 28);
      pt.point_z = round_to_q16(r * longint'(ring_sin[pred_ring]), 14);
      pt.point_intensity = rq.intensity_value;
      pt.ring_number = pred_ring[6:0];
      pt.range_millimetres = mm[41:16];
      pt.keep_point = !(reject && !ordered_q);
      pt.end_of_scan = scan_advance(pred_col_step, pred_ring);
      return pt;
   endfunction

   function automatic void apply_request(req_type rq);
      case (rq.opcode)
         OP_SAMPLE: expected_points.insert(expected_points.size(), convert_sample(rq));
         OP_COL_WRITE: begin
            col_cos[rq.table_index] = rq.cos_value;
            col_sin[rq.table_index] = rq.sin_value;
         end
         OP_RING_WRITE: begin
            if (rq.table_index < MAX_RINGS) begin
               ring_cos[rq.table_index[6:0]] = rq.cos_value;
               ring_sin[rq.table_index[6:0]] = rq.sin_value;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic signed [15:0] random_trig();
      int v;
      v = int'($urandom_range(0, 32768)) - 16384;
      return v[15:0];
   endfunction

   function automatic req_type junk_request();
      req_type rq;
      rq.opcode = 2'($urandom_range(0, 3));
      rq.table_index = 11'($urandom_range(0, 2047));
      rq.cos_value = 16'($urandom());
      rq.sin_value = 16'($urandom());
      rq.range_value = $urandom();
      rq.intensity_value = 16'($urandom());
      return rq;
   endfunction

   task automatic queue_noise();
      req_type rq;
      rq = junk_request();
      rq.opcode = OP_UNUSED;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic queue_table(input logic [1:0] op, input int idx,
                              input logic signed [15:0] c, input logic signed [15:0] s);
      req_type rq;
      rq = junk_request();
      rq.opcode = op;
      rq.table_index = idx[10:0];
      rq.cos_value = c;
      rq.sin_value = s;
      if (op == OP_COL_WRITE) col_loaded[idx] = 1'b1;
      else if (idx < MAX_RINGS) ring_loaded[idx] = 1'b1;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // loads any table entry the sample will read before queuing it
   task automatic queue_sample(input logic [31:0] rng, input logic [15:0] inten);
      req_type rq;
      int      col;
      scan_locate(gen_col_step, gen_ring, col);
      if (!col_loaded[col]) queue_table(OP_COL_WRITE, col, random_trig(), random_trig());
      if (!ring_loaded[gen_ring])
         queue_table(OP_RING_WRITE, gen_ring, random_trig(), random_trig());
      rq = junk_request();
      rq.opcode = OP_SAMPLE;
      rq.range_value = rng;
      rq.intensity_value = inten;
      pending_requests.insert(pending_requests.size(), rq);
      void'(scan_advance(gen_col_step, gen_ring));
   endtask

   task automatic queue_random(input int count);
      int          pick;
      logic [31:0] rng;
      logic [31:0] span;
      logic [15:0] inten;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            queue_noise();
         end else if (pick < 11) begin
            queue_table(OP_COL_WRITE, $urandom_range(0, 2047), random_trig(), random_trig());
         end else if (pick < 15) begin
            queue_table(OP_RING_WRITE,
                        $urandom_range(0, 3) != 0 ? $urandom_range(0, 127)
                                                  : $urandom_range(128, 2047),
                        random_trig(), random_trig());
         end else begin
            span = max_range_q - min_range_q;
            case ($urandom_range(0, 4))
               0: rng = $urandom();
               1: rng = min_range_q + 32'($urandom_range(0, 4)) - 32'd2;
               2: rng = max_range_q + 32'($urandom_range(0, 4)) - 32'd2;
               default: begin
                  if (max_range_q > min_range_q && span > 1)
                     rng = min_range_q + 32'd1 + ($urandom() % (span - 32'd1));
                  else
                     rng = $urandom();
               end
            endcase
            case ($urandom_range(0, 3))
               0: inten = min_int_q;
               1: inten = min_int_q - 16'd1;
               default: inten = 16'($urandom());
            endcase
            queue_sample(rng, inten);
         end
      end
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_RANGE:     min_range_q = val;
         CSR_MAX_RANGE:     max_range_q = val;
         CSR_MIN_INTENSITY: min_int_q = val[15:0];
         CSR_ORDERED_MODE:  ordered_q = val[0];
         CSR_COLUMNS:       columns_q = val[11:0];
         CSR_RINGS:         rings_q = val[7:0];
         default: ;
      endcase
      if (idx == CSR_COLUMNS || idx == CSR_RINGS) begin
         pred_col_step = 0;
         pred_ring = active_rings() - 1;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [15:0] imin, input logic ord,
                                 input logic [11:0] cols, input logic [7:0] rings);
      write_csr(CSR_MIN_RANGE, lo);
      write_csr(CSR_MAX_RANGE, hi);
      write_csr(CSR_MIN_INTENSITY, {16'd0, imin});
      write_csr(CSR_ORDERED_MODE, {31'd0, ord});
      write_csr(CSR_COLUMNS, {20'd0, cols});
      write_csr(CSR_RINGS, {24'd0, rings});
      gen_col_step = pred_col_step;
      gen_ring = pred_ring;
   endtask

   task automatic random_settings();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [15:0] imin;
      int          cols;
      int          rings;
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            cols = $urandom_range(1, 4);
            rings = $urandom_range(1, 4);
         end
         3: begin
            cols = $urandom_range(1, 64);
            rings = $urandom_range(1, 8);
         end
         4: begin
            cols = MAX_COLUMNS;
            rings = $urandom_range(1, 128);
         end
         default: begin
            cols = $urandom_range(0, 4095);
            rings = $urandom_range(0, 255);
         end
      endcase
      lo = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 32'h0008_0000));
      case ($urandom_range(0, 2))
         0: hi = '1;
         1: hi = lo + 32'($urandom_range(0, 32'h0040_0000));
         default: hi = $urandom();
      endcase
      imin = $urandom_range(0, 1) ? 16'd0 : 16'($urandom());
      apply_settings(lo, hi, imin, 1'($urandom_range(0, 1)), 12'(cols), 8'(rings));
   endtask

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      stall_pct = rsp_pct;
   endtask

   // drained: nothing queued or in flight, then room for table writes to land
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [32:0] want,
                              input logic [32:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_point(input point_type pt);
      check_field("point_x", pt.point_x, rsp_point_x);
      check_field("point_y", pt.point_y, rsp_point_y);
      check_field("point_z", pt.point_z, rsp_point_z);
      check_field("point_intensity", pt.point_intensity, rsp_point_intensity);
      check_field("ring_number", pt.ring_number, rsp_ring_number);
      check_field("range_millimetres", pt.range_millimetres, rsp_range_millimetres);
      check_field("keep_point", pt.keep_point, rsp_keep_point);
      check_field("end_of_scan", pt.end_of_scan, rsp_end_of_scan);
   endtask

   lidar_scan_to_point_cloud_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_table_index       (req_table_index),
      .req_cos_value         (req_cos_value),
      .req_sin_value         (req_sin_value),
      .req_range_value       (req_range_value),
      .req_intensity_value   (req_intensity_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_point_x           (rsp_point_x),
      .rsp_point_y           (rsp_point_y),
      .rsp_point_z           (rsp_point_z),
      .rsp_point_intensity   (rsp_point_intensity),
      .rsp_ring_number       (rsp_ring_number),
      .rsp_range_millimetres (rsp_range_millimetres),
      .rsp_keep_point        (rsp_keep_point),
      .rsp_end_of_scan       (rsp_end_of_scan)
   );

   always #10 clock = ~clock;

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_request(in_flight);
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_opcode <= in_flight.opcode;
               req_table_index <= in_flight.table_index;
               req_cos_value <= in_flight.cos_value;
               req_sin_value <= in_flight.sin_value;
               req_range_value <= in_flight.range_value;
               req_intensity_value <= in_flight.intensity_value;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("response with no point pending");
               failures++;
            end else begin
               check_point(expected_points.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);

      // widest geometry, table index filtering, range extremes
      apply_settings(32'd0, '1, 16'd0, 1'b0, 12'd2048, 8'd128);
      queue_noise();
      queue_table(OP_COL_WRITE, 1024, 16384, -16384);
      queue_table(OP_RING_WRITE, 127, -16384, 16384);
      queue_table(OP_RING_WRITE, 2047, 1234, -1234);
      queue_table(OP_RING_WRITE, 255, -77, 77);
      queue_sample(32'hFFFF_FFFE, 16'hFFFF);
      queue_sample(32'd0, 16'd0);
      queue_sample(32'd1, 16'd1);
      queue_sample(32'hFFFF_FFFF, 16'h8000);
      wait_idle();

      // single point scans, ordered mode, band and intensity edges
      apply_settings(32'h0001_0000, 32'h0010_0000, 16'h8000, 1'b1, 12'd1, 8'd1);
      queue_sample(32'h0005_0000, 16'h7FFF);
      queue_table(OP_RING_WRITE, 128, 16384, 16384);
      queue_sample(32'h0001_0001, 16'h8000);
      queue_sample(32'h0001_0000, 16'hFFFF);
      queue_sample(32'h0010_0000, 16'hFFFF);
      queue_sample(32'h000F_FFFF, 16'hFFFF);
      wait_idle();

      // empty band and geometry below the minimum
      apply_settings(32'h0002_0000, 32'h0001_0000, 16'd0, 1'b0, 12'd0, 8'd0);
      queue_sample(32'h0001_8000, 16'h1234);
      queue_sample($urandom(), 16'($urandom()));
      wait_idle();

      // geometry above the maximum
      apply_settings(32'd0, '1, 16'd0, 1'b1, 12'd4095, 8'd255);
      queue_sample(32'h0123_4567, 16'h4321);
      queue_sample(32'h7654_3210, 16'h0F0F);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         random_settings();
         case (p % 4)
            0: set_idling(0, 0);
            1: set_idling(60, 0);
            2: set_idling(0, 60);
            default: set_idling(8, 8);
         endcase
         if (p == 1) begin
            queue_random(60);
            wait_idle();
            queue_random(60);
         end else begin
            queue_random($urandom_range(110, 140));
         end
         wait_idle();
      end

      if (expected_points.size() != 0) failures++;
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
